/* sv/ws2812_frame_serializer_unit_assert.svh */
// Assertion macros for the serializer RTL.
`ifndef WS2812_FRAME_SERIALIZER_UNIT_ASSERT_SVH
`define WS2812_FRAME_SERIALIZER_UNIT_ASSERT_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define WFS_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("wfs: same-cycle check failed");

// Next-cycle implication, checked at every rising edge outside reset.
`define WFS_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("wfs: next-cycle check failed");

`endif

/* sv/wfs_pkg.sv */
// Types, constants and helpers shared by the WS2812 frame serializer.
`default_nettype none
package wfs_pkg;

   localparam int TICK_W  = 10;
   localparam int LEVEL_W = 8;
   localparam int WORD_W  = 32;

   localparam logic [TICK_W-1:0] ONE_HIGH_RESET  = 10'd63;
   localparam logic [TICK_W-1:0] ONE_LOW_RESET   = 10'd45;
   localparam logic [TICK_W-1:0] ZERO_HIGH_RESET = 10'd30;
   localparam logic [TICK_W-1:0] ZERO_LOW_RESET  = 10'd90;

   typedef enum logic [1:0] {
      OP_TICK  = 2'd0,
      OP_WRITE = 2'd1,
      OP_START = 2'd2
   } op_type;

   typedef enum logic [1:0] {
      CSR_ONE_HIGH  = 2'd0,
      CSR_ONE_LOW   = 2'd1,
      CSR_ZERO_HIGH = 2'd2,
      CSR_ZERO_LOW  = 2'd3
   } csr_type;

   typedef struct packed {
      logic [TICK_W-1:0] one_high;
      logic [TICK_W-1:0] one_low;
      logic [TICK_W-1:0] zero_high;
      logic [TICK_W-1:0] zero_low;
   } timing_type;

   typedef struct packed {
      logic [LEVEL_W-1:0] line_levels;
      logic               busy_res;
      logic               frame_done;
      logic               accepted;
   } rsp_type;

   // Swaps the two middle bytes, turning an RGB word into GRB order.
   function automatic logic [WORD_W-1:0] swap_middle(input logic [WORD_W-1:0] w);
      return {w[31:24], w[15:8], w[23:16], w[7:0]};
   endfunction

endpackage
`default_nettype wire

/* sv/wfs_ram.sv */
// Generic single-write, single-read RAM with a registered read port.
`default_nettype none
module wfs_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 16,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

/* sv/wfs_skid.sv */
// Two-entry output buffer that decouples result transfers from input transfers.
`default_nettype none
module wfs_skid (
   input  logic            clock,
   input  logic            reset,
   input  logic            in_valid,
   input  wfs_pkg::rsp_type in_data,
   output logic            full,
   output logic            out_valid,
   output wfs_pkg::rsp_type out_data,
   input  logic            out_stall
);
   import wfs_pkg::*;

   logic    out_valid_ff, out_valid_in;
   rsp_type out_data_ff, out_data_in;
   logic    skid_valid_ff, skid_valid_in;
   rsp_type skid_data_ff, skid_data_in;

   always_comb begin
      out_valid_in  = out_valid_ff;
      out_data_in   = out_data_ff;
      skid_valid_in = skid_valid_ff;
      skid_data_in  = skid_data_ff;
      if (out_valid_ff && out_stall) begin
         if (in_valid && !skid_valid_ff) begin
            skid_valid_in = 1'b1;
            skid_data_in  = in_data;
         end
      end else if (skid_valid_ff) begin
         out_valid_in  = 1'b1;
         out_data_in   = skid_data_ff;
         skid_valid_in = 1'b0;
      end else begin
         out_valid_in = in_valid;
         out_data_in  = in_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      out_data_ff  <= out_data_in;
      skid_data_ff <= skid_data_in;
   end

   assign full      = skid_valid_ff;
   assign out_valid = out_valid_ff;
   assign out_data  = out_data_ff;

endmodule
`default_nettype wire

/* sv/wfs_sequencer.sv */
// Waveform sequencer: frame state, slot valid bits and colour store access.
`default_nettype none
module wfs_sequencer #(
   parameter int SLOTS = 16,
   parameter int LINES = 8,
   parameter int BITS_PER_LED = 24,
   localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1,
   localparam int POS_W  = $clog2(SLOTS + 1),
   localparam int LINE_W = (LINES > 1) ? $clog2(LINES) : 1,
   localparam int BIT_W  = $clog2(BITS_PER_LED)
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    take,
   input  logic [1:0]              op,
   input  logic [3:0]              slot,
   input  logic [31:0]             word,
   input  logic [4:0]              count,
   input  logic [2:0]              line,
   input  wfs_pkg::timing_type     timing,
   input  logic [BITS_PER_LED-1:0] ram_rd_data,
   output logic                    ram_wr_en,
   output logic [SLOT_W-1:0]       ram_wr_addr,
   output logic [BITS_PER_LED-1:0] ram_wr_data,
   output logic [SLOT_W-1:0]       ram_rd_addr,
   output wfs_pkg::rsp_type        result
);
   import wfs_pkg::*;

   logic              sending_ff, sending_in;
   logic              phase_high_ff, phase_high_in;
   logic [TICK_W-1:0] phase_cnt_ff, phase_cnt_in;
   logic [BIT_W-1:0]  bit_pos_ff, bit_pos_in;
   logic [SLOT_W-1:0] led_pos_ff, led_pos_in;
   logic [POS_W-1:0]  leds_total_ff, leds_total_in;
   logic [LINE_W-1:0] active_line_ff, active_line_in;
   logic [SLOTS-1:0]  slot_valid_ff, slot_valid_in;
   logic              rd_valid_ff;

   logic [BITS_PER_LED-1:0] cur_word;
   logic                    cur_bit;
   logic [TICK_W-1:0]       dur;
   logic [TICK_W-1:0]       dur_eff;
   logic [TICK_W-1:0]       cnt_inc;
   logic                    phase_end;
   logic [POS_W-1:0]        led_next;
   logic [POS_W-1:0]        count_sat;
   logic [2:0]              line_wrap;
   logic [LEVEL_W-1:0]      levels;
   logic [WORD_W-1:0]       swapped;
   logic                    done;
   logic                    acc;

   assign cur_word = rd_valid_ff ? ram_rd_data : '0;
   assign cur_bit  = cur_word[BIT_W'(BITS_PER_LED - 1) - bit_pos_ff];
   assign cnt_inc  = phase_cnt_ff + TICK_W'(1);
   assign swapped  = swap_middle(word);

   always_comb begin
      if (phase_high_ff) begin
         dur = cur_bit ? timing.one_high : timing.zero_high;
      end else begin
         dur = cur_bit ? timing.one_low : timing.zero_low;
      end
      dur_eff   = (dur == '0) ? TICK_W'(1) : dur;
      phase_end = (cnt_inc >= dur_eff) || (cnt_inc == '0);
   end

   always_comb begin
      if (32'(count) > SLOTS) begin
         count_sat = POS_W'(SLOTS);
      end else begin
         count_sat = POS_W'(count);
      end
      line_wrap = line;
      for (int k = 0; k < 8; k++) begin
         if (32'(line_wrap) >= LINES) begin
            line_wrap = 3'(32'(line_wrap) - LINES);
         end
      end
      for (int i = 0; i < LEVEL_W; i++) begin
         levels[i] = sending_ff && phase_high_ff && (32'(active_line_ff) == i);
      end
   end

   always_comb begin
      sending_in     = sending_ff;
      phase_high_in  = phase_high_ff;
      phase_cnt_in   = phase_cnt_ff;
      bit_pos_in     = bit_pos_ff;
      led_pos_in     = led_pos_ff;
      leds_total_in  = leds_total_ff;
      active_line_in = active_line_ff;
      slot_valid_in  = slot_valid_ff;
      led_next       = POS_W'(led_pos_ff);
      ram_wr_en      = 1'b0;
      ram_wr_addr    = SLOT_W'(slot);
      ram_wr_data    = swapped[BITS_PER_LED-1:0];
      done           = 1'b0;
      acc            = 1'b0;
      if (take) begin
         unique case (op)
            OP_TICK: begin
               if (sending_ff) begin
                  phase_cnt_in = cnt_inc;
                  if (phase_end) begin
                     phase_cnt_in = '0;
                     if (phase_high_ff) begin
                        phase_high_in = 1'b0;
                     end else begin
                        if (bit_pos_ff == BIT_W'(BITS_PER_LED - 1)) begin
                           bit_pos_in = '0;
                           led_next   = POS_W'(led_pos_ff) + POS_W'(1);
                        end else begin
                           bit_pos_in = bit_pos_ff + BIT_W'(1);
                        end
                        if (led_next >= leds_total_ff) begin
                           sending_in = 1'b0;
                           led_pos_in = '0;
                           done       = 1'b1;
                        end else begin
                           phase_high_in = 1'b1;
                           led_pos_in    = SLOT_W'(led_next);
                        end
                     end
                  end
               end
            end
            OP_WRITE: begin
               if (!sending_ff && (32'(slot) < SLOTS)) begin
                  ram_wr_en                    = 1'b1;
                  slot_valid_in[SLOT_W'(slot)] = 1'b1;
                  acc                          = 1'b1;
               end
            end
            OP_START: begin
               if (!sending_ff) begin
                  acc = 1'b1;
                  if (count_sat != '0) begin
                     active_line_in = LINE_W'(line_wrap);
                     leds_total_in  = count_sat;
                     led_pos_in     = '0;
                     bit_pos_in     = '0;
                     phase_high_in  = 1'b1;
                     phase_cnt_in   = '0;
                     sending_in     = 1'b1;
                  end
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sending_ff     <= 1'b0;
         phase_high_ff  <= 1'b0;
         phase_cnt_ff   <= '0;
         bit_pos_ff     <= '0;
         led_pos_ff     <= '0;
         leds_total_ff  <= '0;
         active_line_ff <= '0;
         slot_valid_ff  <= '0;
         rd_valid_ff    <= 1'b0;
      end else begin
         sending_ff     <= sending_in;
         phase_high_ff  <= phase_high_in;
         phase_cnt_ff   <= phase_cnt_in;
         bit_pos_ff     <= bit_pos_in;
         led_pos_ff     <= led_pos_in;
         leds_total_ff  <= leds_total_in;
         active_line_ff <= active_line_in;
         slot_valid_ff  <= slot_valid_in;
         rd_valid_ff    <= slot_valid_ff[led_pos_in];
      end
   end

   assign ram_rd_addr        = led_pos_in;
   assign result.line_levels = levels;
   assign result.busy_res    = sending_in;
   assign result.frame_done  = done;
   assign result.accepted    = acc;

endmodule
`default_nettype wire

/* sv/ws2812_frame_serializer_unit.sv */
// A result is formed combinationally from its input transfer and registered in the output buffer.
// Throughput: one item per cycle while the output buffer is not full; the sequencer reads the colour RAM every cycle.
// The output buffer holds two results, so input stalls only when both are full.
// Reset clears the frame state, the slot valid bits and the output buffer, and loads
// the default pulse timing; the colour RAM needs no clearing pass.
`default_nettype none
module ws2812_frame_serializer_unit #(
   parameter int SLOTS = 16,
   parameter int LINES = 8,
   parameter int BITS_PER_LED = 24
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_operation,
   input  logic [3:0]  req_slot_index,
   input  logic [31:0] req_color_word,
   input  logic [4:0]  req_led_count,
   input  logic [2:0]  req_line_select,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_line_levels,
   output logic        rsp_busy_res,
   output logic        rsp_frame_done,
   output logic        rsp_accepted,
   input  logic        csr_wr_en,
   input  logic [1:0]  csr_index,
   input  logic [9:0]  csr_wr_data
);
   import wfs_pkg::*;

   `include "ws2812_frame_serializer_unit_assert.svh"

   localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

   timing_type timing_ff, timing_in;
   logic       take;
   logic       buf_full;
   rsp_type    seq_rsp;
   rsp_type    out_rsp;

   logic                    ram_wr_en;
   logic [SLOT_W-1:0]       ram_wr_addr;
   logic [BITS_PER_LED-1:0] ram_wr_data;
   logic [SLOT_W-1:0]       ram_rd_addr;
   logic [BITS_PER_LED-1:0] ram_rd_data;

   always_comb begin
      timing_in = timing_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            CSR_ONE_HIGH:  timing_in.one_high  = csr_wr_data;
            CSR_ONE_LOW:   timing_in.one_low   = csr_wr_data;
            CSR_ZERO_HIGH: timing_in.zero_high = csr_wr_data;
            CSR_ZERO_LOW:  timing_in.zero_low  = csr_wr_data;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         timing_ff.one_high  <= ONE_HIGH_RESET;
         timing_ff.one_low   <= ONE_LOW_RESET;
         timing_ff.zero_high <= ZERO_HIGH_RESET;
         timing_ff.zero_low  <= ZERO_LOW_RESET;
      end else begin
         timing_ff <= timing_in;
      end
   end

   assign req_stall = buf_full;
   assign take      = req_valid && !buf_full;

   wfs_ram #(
      .WIDTH(BITS_PER_LED),
      .DEPTH(SLOTS)
   ) u_color_ram (
      .clock  (clock),
      .wr_en  (ram_wr_en),
      .wr_addr(ram_wr_addr),
      .wr_data(ram_wr_data),
      .rd_addr(ram_rd_addr),
      .rd_data(ram_rd_data)
   );

   wfs_sequencer #(
      .SLOTS(SLOTS),
      .LINES(LINES),
      .BITS_PER_LED(BITS_PER_LED)
   ) u_sequencer (
      .clock      (clock),
      .reset      (reset),
      .take       (take),
      .op         (req_operation),
      .slot       (req_slot_index),
      .word       (req_color_word),
      .count      (req_led_count),
      .line       (req_line_select),
      .timing     (timing_ff),
      .ram_rd_data(ram_rd_data),
      .ram_wr_en  (ram_wr_en),
      .ram_wr_addr(ram_wr_addr),
      .ram_wr_data(ram_wr_data),
      .ram_rd_addr(ram_rd_addr),
      .result     (seq_rsp)
   );

   wfs_skid u_out_buf (
      .clock    (clock),
      .reset    (reset),
      .in_valid (take),
      .in_data  (seq_rsp),
      .full     (buf_full),
      .out_valid(rsp_valid),
      .out_data (out_rsp),
      .out_stall(rsp_stall)
   );

   assign rsp_line_levels = out_rsp.line_levels;
   assign rsp_busy_res    = out_rsp.busy_res;
   assign rsp_frame_done  = out_rsp.frame_done;
   assign rsp_accepted    = out_rsp.accepted;

   `WFS_ASSERT_NOW(a_full_has_output, clock, reset, buf_full, rsp_valid)
   `WFS_ASSERT_NOW(a_done_ends_frame, clock, reset, rsp_valid && rsp_frame_done, !rsp_busy_res && !rsp_accepted)
   `WFS_ASSERT_NOW(a_accept_needs_op, clock, reset, take && seq_rsp.accepted, req_operation == OP_WRITE || req_operation == OP_START)
   `WFS_ASSERT_NEXT(a_fill_on_stall, clock, reset, take && rsp_valid && rsp_stall, buf_full)

endmodule
`default_nettype wire
